// ===== hw/rtl/foct_pkg.sv =====
// ----------------------------------------------------------------------------
// foct_pkg
// Shared constants and types for the frequency-ordered counter table:
// table geometry, command codes and the control/status bundles that run
// between the controller and the cell datapath.
// ----------------------------------------------------------------------------
package foct_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int USED_W  = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 32;
  localparam int CNT_W   = 32;
  localparam int POS_W   = 6;

  localparam logic CMD_INCR   = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // Commands from controller to datapath, at most one table action per cycle.
  typedef struct packed {
    logic capture;   // latch the incoming item
    logic search;    // compare key in every cell, register hit
    logic add;       // saturating sum of hit count and amount
    logic compare;   // compare every cell count against the new sum
    logic move;      // shift entries down and drop hit entry into place
    logic append;    // write new key at the end of the table
    logic out_load;  // copy result into the output register
  } ctrl_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic is_lookup;
    logic found;
    logic full;
  } dp_status_t;

  // Low POS_W bits of a table index, zero-extended when the index is narrower.
  function automatic logic [POS_W-1:0] to_pos(input logic [IDX_W-1:0] idx);
    logic [POS_W+IDX_W-1:0] ext;
    ext = {{POS_W{1'b0}}, idx};
    return ext[POS_W-1:0];
  endfunction

endpackage

// ===== hw/rtl/frequency_ordered_counter_table_core.sv =====
// ----------------------------------------------------------------------------
// frequency_ordered_counter_table_core
// Key/count table kept in descending count order, with increment and lookup.
// ----------------------------------------------------------------------------
// The table holds up to ENTRIES key/count pairs in a row of cells, each with
// its own key comparator, so one search covers every cell whatever the fill.
// One item is worked at a time. A lookup or a dropped key goes through the
// search, then the output load. An appended key goes through search, append
// and output load. An increment of a present key goes through the search,
// the saturating add, the compare of every cell count against the new sum,
// one parallel shift that drops the entry into place, and the output load.
// The output load waits while the output register still holds an untaken
// result. The next item can be accepted in the cycle after the output load.
// The result waits in an output register. Once it is loaded, the next item
// is taken while it still waits. A new key on a full table is dropped and
// reported with table_full set.
module frequency_ordered_counter_table_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       command_i,
  input  logic [foct_pkg::KEY_W-1:0] key_i,
  input  logic [foct_pkg::CNT_W-1:0] amount_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [foct_pkg::CNT_W-1:0] count_o,
  output logic [foct_pkg::POS_W-1:0] position_o,
  output logic                       found_o,
  output logic                       table_full_o
);
  import foct_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  foct_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  foct_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .command_i    (command_i),
    .key_i        (key_i),
    .amount_i     (amount_i),
    .count_o      (count_o),
    .position_o   (position_o),
    .found_o      (found_o),
    .table_full_o (table_full_o)
  );

endmodule

// ===== hw/rtl/foct_ctrl.sv =====
// ----------------------------------------------------------------------------
// foct_ctrl
// Sequencer for one item: search, then lookup reply, append, or the
// add / compare / move sequence, then hand the result to the output register.
// ----------------------------------------------------------------------------
module foct_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  foct_pkg::dp_status_t  status_i,
  output foct_pkg::ctrl_cmd_t   cmd_o
);
  import foct_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_SEARCH = 7'b0000010,
    ST_APPEND = 7'b0000100,
    ST_ADD    = 7'b0001000,
    ST_CMP    = 7'b0010000,
    ST_MOVE   = 7'b0100000,
    ST_RESULT = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        priority if (status_i.is_lookup) begin
          state_d = ST_RESULT;
        end else if (status_i.found) begin
          state_d = ST_ADD;
        end else if (status_i.full) begin
          state_d = ST_RESULT;
        end else begin
          state_d = ST_APPEND;
        end
      end
      ST_APPEND: begin
        cmd_o.append = 1'b1;
        state_d      = ST_RESULT;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_CMP;
      end
      ST_CMP: begin
        cmd_o.compare = 1'b1;
        state_d       = ST_MOVE;
      end
      ST_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = ST_RESULT;
      end
      ST_RESULT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/foct_datapath.sv =====
// ----------------------------------------------------------------------------
// foct_datapath
// Row of key/count cells with a comparator in each, the saturating adder,
// the insertion-point encoder and the result and output registers.
// ----------------------------------------------------------------------------
module foct_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  foct_pkg::ctrl_cmd_t        cmd_i,
  output foct_pkg::dp_status_t       status_o,
  input  logic                       command_i,
  input  logic [foct_pkg::KEY_W-1:0] key_i,
  input  logic [foct_pkg::CNT_W-1:0] amount_i,
  output logic [foct_pkg::CNT_W-1:0] count_o,
  output logic [foct_pkg::POS_W-1:0] position_o,
  output logic                       found_o,
  output logic                       table_full_o
);
  import foct_pkg::*;

  // captured item
  logic             cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [CNT_W-1:0] amount_q;

  // cell row
  logic [KEY_W-1:0]  keys_q   [ENTRIES];
  logic [CNT_W-1:0]  counts_q [ENTRIES];
  logic [USED_W-1:0] used_q;

  // search and update working registers
  logic             found_q;
  logic [IDX_W-1:0] hit_idx_q;
  logic [CNT_W-1:0] hit_cnt_q;
  logic [CNT_W-1:0] sum_q;
  logic [ENTRIES-1:0] lt_q;

  // staged result and output register
  logic [CNT_W-1:0] res_count_q, res_count_d;
  logic [POS_W-1:0] res_pos_q, res_pos_d;
  logic             res_found_q, res_found_d;
  logic             res_full_q, res_full_d;
  logic [CNT_W-1:0] out_count_q;
  logic [POS_W-1:0] out_pos_q;
  logic             out_found_q;
  logic             out_full_q;

  logic [ENTRIES-1:0] match;
  logic               hit_any;
  logic [IDX_W-1:0]   hit_idx;
  logic [CNT_W-1:0]   hit_cnt;
  logic               full;
  logic [CNT_W:0]     sum_wide;
  logic [IDX_W-1:0]   ins_idx;
  logic [IDX_W-1:0]   used_idx;

  assign full     = (used_q == USED_W'(ENTRIES));
  assign used_idx = used_q[IDX_W-1:0];
  assign sum_wide = {1'b0, hit_cnt_q} + {1'b0, amount_q};

  // parallel key compare; keys are unique, so at most one cell hits
  always_comb begin
    match   = '0;
    hit_idx = '0;
    hit_cnt = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      match[j] = (keys_q[j] == key_q) && (USED_W'(j) < used_q);
      hit_idx  = hit_idx | (match[j] ? IDX_W'(j) : '0);
      hit_cnt  = hit_cnt | (match[j] ? counts_q[j] : '0);
    end
    hit_any = |match;
  end

  // insertion point: one past the last cell in front of the hit whose count
  // is not smaller than the new sum
  always_comb begin
    ins_idx = '0;
    for (int j = 0; j < ENTRIES; j++) begin
      if ((IDX_W'(j) < hit_idx_q) && !lt_q[j]) begin
        ins_idx = IDX_W'(j) + IDX_W'(1);
      end
    end
  end

  assign status_o.is_lookup = (cmd_q == CMD_LOOKUP);
  assign status_o.found     = hit_any;
  assign status_o.full      = full;

  always_comb begin
    res_count_d = res_count_q;
    res_pos_d   = res_pos_q;
    res_found_d = res_found_q;
    res_full_d  = res_full_q;
    priority if (cmd_i.search) begin
      // lookup reply, or dropped key; other cases are overwritten later
      res_count_d = (cmd_q == CMD_LOOKUP && hit_any) ? hit_cnt : '0;
      res_pos_d   = (cmd_q == CMD_LOOKUP && hit_any) ? to_pos(hit_idx) : '0;
      res_found_d = (cmd_q == CMD_LOOKUP) && hit_any;
      res_full_d  = (cmd_q == CMD_INCR) && !hit_any && full;
    end else if (cmd_i.append) begin
      res_count_d = amount_q;
      res_pos_d   = to_pos(used_idx);
      res_found_d = 1'b0;
      res_full_d  = 1'b0;
    end else if (cmd_i.move) begin
      res_count_d = sum_q;
      res_pos_d   = to_pos(ins_idx);
      res_found_d = 1'b1;
      res_full_d  = 1'b0;
    end else begin
      res_count_d = res_count_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= command_i;
      key_q    <= key_i;
      amount_q <= amount_i;
    end
    if (cmd_i.search) begin
      found_q   <= hit_any;
      hit_idx_q <= hit_idx;
      hit_cnt_q <= hit_cnt;
    end
    if (cmd_i.add) begin
      sum_q <= sum_wide[CNT_W] ? '1 : sum_wide[CNT_W-1:0];
    end
    if (cmd_i.compare) begin
      for (int j = 0; j < ENTRIES; j++) begin
        lt_q[j] <= counts_q[j] < sum_q;
      end
    end
    res_count_q <= res_count_d;
    res_pos_q   <= res_pos_d;
    res_found_q <= res_found_d;
    res_full_q  <= res_full_d;
    if (cmd_i.out_load) begin
      out_count_q <= res_count_q;
      out_pos_q   <= res_pos_q;
      out_found_q <= res_found_q;
      out_full_q  <= res_full_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else if (cmd_i.append) begin
      used_q <= used_q + USED_W'(1);
    end
  end

  // cells: the hit entry lands at the insertion point, the run in between
  // shifts one place toward the back
  for (genvar j = 0; j < ENTRIES; j++) begin : g_cell
    if (j == 0) begin : g_head
      always_ff @(posedge clk_i) begin
        if (cmd_i.move && found_q && ins_idx == IDX_W'(j)) begin
          keys_q[j]   <= key_q;
          counts_q[j] <= sum_q;
        end else if (cmd_i.append && used_idx == IDX_W'(j)) begin
          keys_q[j]   <= key_q;
          counts_q[j] <= amount_q;
        end
      end
    end else begin : g_body
      always_ff @(posedge clk_i) begin
        if (cmd_i.move && found_q && ins_idx == IDX_W'(j)) begin
          keys_q[j]   <= key_q;
          counts_q[j] <= sum_q;
        end else if (cmd_i.move && found_q && ins_idx < IDX_W'(j)
                     && IDX_W'(j) <= hit_idx_q) begin
          keys_q[j]   <= keys_q[j-1];
          counts_q[j] <= counts_q[j-1];
        end else if (cmd_i.append && used_idx == IDX_W'(j)) begin
          keys_q[j]   <= key_q;
          counts_q[j] <= amount_q;
        end
      end
    end
  end

  assign count_o      = out_count_q;
  assign position_o   = out_pos_q;
  assign found_o      = out_found_q;
  assign table_full_o = out_full_q;

endmodule

// ===== hw/rtl/foct_checker.sv =====
// ----------------------------------------------------------------------------
// foct_checker
// Port-level checks on the counter table core, bound to the top level.
// ----------------------------------------------------------------------------
module foct_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_o,
  input logic                       command_i,
  input logic [foct_pkg::KEY_W-1:0] key_i,
  input logic [foct_pkg::CNT_W-1:0] amount_i,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [foct_pkg::CNT_W-1:0] count_o,
  input logic [foct_pkg::POS_W-1:0] position_o,
  input logic                       found_o,
  input logic                       table_full_o
);
  import foct_pkg::*;

  // a stalled item holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(count_o)
      && $stable(position_o) && $stable(found_o) && $stable(table_full_o))
    else $error("output item changed while stalled");

  // one item at a time: busy right after acceptance
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted while an item is in progress");

  a_found_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && table_full_o))
    else $error("found and table_full both set");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> count_o == '0 && position_o == '0)
    else $error("dropped key reports a count or position");

endmodule

bind frequency_ordered_counter_table_core foct_checker u_foct_checker (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for the frequency-ordered counter table. A driver offers
// increment and lookup items from a queue, a software copy of the table
// predicts count, position, found and table_full for every accepted item,
// and a monitor checks each result in order against that prediction.
// ----------------------------------------------------------------------------
module tb;

  import foct_pkg::*;

  localparam int RAND_ITEMS = 1800;
  localparam int POOL_KEYS  = 80;
  localparam int HOLD_LEN   = 300;
  localparam int HOLD_AT    = 1300;

  typedef struct packed {
    logic             command;
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] amount;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [POS_W-1:0] position;
    logic             found;
    logic             table_full;
  } result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic             command = CMD_INCR;
  logic [KEY_W-1:0] key = '0;
  logic [CNT_W-1:0] amount = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [CNT_W-1:0] count;
  logic [POS_W-1:0] position;
  logic             found;
  logic             table_full;

  // software copy of the table
  logic [KEY_W-1:0] tbl_key [ENTRIES];
  logic [CNT_W-1:0] tbl_cnt [ENTRIES];
  int               tbl_used = 0;

  item_t            pending_items[$];
  result_t          predicted_q[$];
  logic [KEY_W-1:0] key_pool [POOL_KEYS];

  logic             in_taken = 1'b0;
  logic             stim_done = 1'b0;
  int               n_accepted = 0;
  int               hold_left = 0;
  logic             hold_done = 1'b0;
  int               errors = 0;

  frequency_ordered_counter_table_core u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .command_i    (command),
    .key_i        (key),
    .amount_i     (amount),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .count_o      (count),
    .position_o   (position),
    .found_o      (found),
    .table_full_o (table_full)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("tb: errors");
    $finish;
  end

  // Apply one item to the table copy and return what the block should report.
  function automatic result_t table_apply(input item_t it);
    result_t          r;
    int               hit;
    int               idx;
    logic [CNT_W:0]   sum;
    logic [KEY_W-1:0] tk;
    logic [CNT_W-1:0] tc;
    r   = '0;
    hit = -1;
    for (int i = 0; i < tbl_used; i++) begin
      if (hit < 0 && tbl_key[i] == it.key) hit = i;
    end
    if (it.command == CMD_LOOKUP) begin
      if (hit >= 0) begin
        r.count    = tbl_cnt[hit];
        r.position = POS_W'(hit);
        r.found    = 1'b1;
      end
    end else if (hit >= 0) begin
      sum = {1'b0, tbl_cnt[hit]} + {1'b0, it.amount};
      tbl_cnt[hit] = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
      idx = hit;
      // bubble forward past strictly smaller counts only
      while (idx > 0 && tbl_cnt[idx-1] < tbl_cnt[idx]) begin
        tk = tbl_key[idx-1];
        tc = tbl_cnt[idx-1];
        tbl_key[idx-1] = tbl_key[idx];
        tbl_cnt[idx-1] = tbl_cnt[idx];
        tbl_key[idx]   = tk;
        tbl_cnt[idx]   = tc;
        idx--;
      end
      r.count    = tbl_cnt[idx];
      r.position = POS_W'(idx);
      r.found    = 1'b1;
    end else if (tbl_used >= ENTRIES) begin
      r.table_full = 1'b1;
    end else begin
      tbl_key[tbl_used] = it.key;
      tbl_cnt[tbl_used] = it.amount;
      r.count    = it.amount;
      r.position = POS_W'(tbl_used);
      tbl_used++;
    end
    return r;
  endfunction

  function automatic int send_idle_pct();
    return (n_accepted < 600) ? 25 : (n_accepted < 1200) ? 80 : 0;
  endfunction

  function automatic int recv_idle_pct();
    return (n_accepted < 600) ? 80 : (n_accepted < 1200) ? 25 : 0;
  endfunction

  task automatic add_item(input logic cmd, input logic [KEY_W-1:0] k,
                          input logic [CNT_W-1:0] amt);
    item_t it;
    it.command = cmd;
    it.key     = k;
    it.amount  = amt;
    pending_items.push_back(it);
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_val,
                             input logic [CNT_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      errors++;
    end
  endtask

  // Driver: offer the next item once the current one is gone.
  always @(negedge clk) begin : drive_p
    item_t it;
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_items.size() == 0) begin
        in_valid  <= 1'b0;
        stim_done <= 1'b1;
      end else if ($urandom_range(99) >= send_idle_pct()) begin
        it = pending_items.pop_front();
        in_valid <= 1'b1;
        command  <= it.command;
        key      <= it.key;
        amount   <= it.amount;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off so the block backs up into its input.
  always @(negedge clk) begin
    if (!hold_done && n_accepted >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && hold_left == 0 && $urandom_range(99) >= recv_idle_pct();
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk) begin : monitor_p
    item_t   it;
    result_t exp_r;
    if (rst_n) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        it.command = command;
        it.key     = key;
        it.amount  = amount;
        predicted_q.push_back(table_apply(it));
        n_accepted <= n_accepted + 1;
      end
      if (out_valid && out_ready) begin
        if (predicted_q.size() == 0) begin
          $error("result with no item outstanding: count %0h position %0d", count, position);
          errors++;
        end else begin
          exp_r = predicted_q.pop_front();
          check_field("count", exp_r.count, count);
          check_field("position", CNT_W'(exp_r.position), CNT_W'(position));
          check_field("found", CNT_W'(exp_r.found), CNT_W'(found));
          check_field("table_full", CNT_W'(exp_r.table_full), CNT_W'(table_full));
        end
      end
    end
  end

  initial begin
    int               r;
    logic             cmd;
    logic [KEY_W-1:0] k;
    logic [CNT_W-1:0] amt;

    foreach (key_pool[i]) key_pool[i] = $urandom;

    // Directed: absent lookup, append of zero and max, saturation, equal counts
    // keeping order, a move forward past smaller counts, appended key staying at the end.
    add_item(CMD_LOOKUP, 32'h0000_0005, 32'hFFFF_FFFF);
    add_item(CMD_INCR,   32'h0000_0000, 32'h0000_0000);
    add_item(CMD_INCR,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    add_item(CMD_INCR,   32'h0000_0000, 32'h0000_0000);
    add_item(CMD_INCR,   32'hFFFF_FFFF, 32'h0000_0001);
    add_item(CMD_INCR,   32'h0000_0000, 32'hFFFF_FFFF);
    add_item(CMD_LOOKUP, 32'h0000_0000, 32'h1234_5678);
    add_item(CMD_INCR,   32'h0000_0011, 32'h0000_0003);
    add_item(CMD_INCR,   32'h0000_0022, 32'h0000_0003);
    add_item(CMD_INCR,   32'h0000_0033, 32'h0000_0002);
    add_item(CMD_INCR,   32'h0000_0033, 32'h0000_0001);
    add_item(CMD_INCR,   32'h0000_0033, 32'h0000_0001);
    add_item(CMD_LOOKUP, 32'h0000_0022, 32'h0000_0000);
    add_item(CMD_LOOKUP, 32'h0000_0033, 32'h0000_0000);
    add_item(CMD_INCR,   32'hA5A5_A5A5, 32'h5A5A_5A5A);
    add_item(CMD_LOOKUP, 32'h5A5A_5A5A, 32'h0000_0000);
    add_item(CMD_INCR,   32'h0000_0011, 32'hFFFF_FFFE);
    add_item(CMD_LOOKUP, 32'h0000_0011, 32'h0000_0000);

    // Random: mostly a pool a bit larger than the table so it fills, reorders
    // and then starts dropping new keys; small amounts keep counts close.
    repeat (RAND_ITEMS) begin
      cmd = ($urandom_range(99) < 25) ? CMD_LOOKUP : CMD_INCR;
      r = $urandom_range(99);
      if (r < 85)      k = key_pool[$urandom_range(POOL_KEYS - 1)];
      else if (r < 95) k = $urandom;
      else             k = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      r = $urandom_range(999);
      if (r < 700)      amt = $urandom_range(15);
      else if (r < 950) amt = $urandom_range(100000);
      else if (r < 990) amt = $urandom >> 8;
      else if (r < 997) amt = $urandom;
      else              amt = 32'hFFFF_FFF0 + $urandom_range(15);
      add_item(cmd, k, amt);
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (!stim_done || predicted_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
